>>> sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// Route table engine package
// Shared types, codes and default sizes for the route table cell chain.
// ----------------------------------------------------------------------------
package rte_pkg;

	// Default table depth and key width in bytes.
	localparam int RTE_ENTRIES  = 16;
	localparam int RTE_ID_BYTES = 8;

	// Fixed payload widths.
	localparam int HOP_W   = 64;
	localparam int COST_W  = 8;
	localparam int STAMP_W = 32;
	localparam int COUNT_W = 5;

	// Operation codes.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_LOOKUP = 2'd3
	} rte_action_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_FULL = 2'd2,
		STAT_MISS = 2'd3
	} rte_status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC
	} rte_state_t;

	// Entry payload other than the key.
	typedef struct packed {
		logic [HOP_W-1:0]   hop;
		logic [COST_W-1:0]  cost;
		logic [STAMP_W-1:0] stamp;
	} rte_data_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;
		logic ins;
		logic upd;
		logic rem;
	} rte_ctl_t;

endpackage

>>> sv/rte_cell.sv
// ----------------------------------------------------------------------------
// Route table cell
// Holds one table entry, compares it with the query key and takes part in
// the first-hit chain, the lookup chain and the shift-down on remove.
// ----------------------------------------------------------------------------
module rte_cell import rte_pkg::*; #(
	parameter int IDX   = 0,
	parameter int KEY_W = 64,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  rte_ctl_t         ctl,
	input  logic [KEY_W-1:0] qkey,
	input  rte_data_t        qdata,
	input  logic [KEY_W-1:0] nxt_key,
	input  rte_data_t        nxt_data,
	input  logic             hit_in,
	input  rte_data_t        found_in,
	output logic [KEY_W-1:0] key_out,
	output rte_data_t        data_out,
	output logic             hit_out,
	output rte_data_t        found_out,
	output logic             hit_first
);

	logic [KEY_W-1:0] key_q;
	rte_data_t        data_q;
	logic             hit_q;
	logic             valid;
	logic             at_tail;

	// The cell holds a live entry when its slot lies below the count.
	assign valid   = CNT_W'(IDX) < count;
	assign at_tail = CNT_W'(IDX) == count;

	// Registered key compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			hit_q <= valid && (key_q == qkey);
		end
	end

	// The first hit claims the match; every cell at or after it is marked.
	assign hit_first = hit_q && !hit_in;
	assign hit_out   = hit_q || hit_in;

	// Matched payload travels along the chain toward the end.
	assign found_out = rte_data_t'(found_in | (hit_first ? data_q : '0));

	// Entry storage: shift down on remove, append at the tail, or rewrite.
	always_ff @(posedge clk) begin
		if (ctl.rem && hit_out) begin
			key_q  <= nxt_key;
			data_q <= nxt_data;
		end else if (ctl.ins && at_tail) begin
			key_q  <= qkey;
			data_q <= qdata;
		end else if (ctl.upd && hit_first) begin
			data_q <= qdata;
		end
	end

	assign key_out  = key_q;
	assign data_out = data_q;

endmodule

>>> sv/route_table_engine_top.sv
// ----------------------------------------------------------------------------
// Route table engine
// Keyed route table built as a chain of entry cells with a small sequencer.
// ----------------------------------------------------------------------------
// The sequencer takes an item while idle, then runs a registered key compare
// in all cells and an execute step along the cell chain; done and the result
// are registered. Busy is high while an item is in flight and is low again in
// the done cycle, so a new item is taken only once the previous one is done.
// Reset clears the entry count and the sequencer; entry storage is not cleared.
// The receiver cannot stall: done is a single-cycle strobe.
module route_table_engine_top import rte_pkg::*; #(
	parameter int TABLE_ENTRIES = RTE_ENTRIES,
	parameter int ID_BYTES      = RTE_ID_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [63:0]        dest_key,
	input  logic [HOP_W-1:0]   hop_key,
	input  logic [COST_W-1:0]  route_cost,
	input  logic [STAMP_W-1:0] route_stamp,
	output logic               done,
	output logic [1:0]         status,
	output logic [HOP_W-1:0]   found_hop,
	output logic [COST_W-1:0]  found_cost,
	output logic [STAMP_W-1:0] found_stamp,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int KEY_W = 8 * ID_BYTES;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	rte_state_t       state_q, state_d;
	rte_action_t      act_q;
	logic [KEY_W-1:0] key_q;
	rte_data_t        qdata_q;
	logic [CNT_W-1:0] count_q;
	rte_ctl_t         ctl;

	logic                   done_q;
	rte_status_t            status_q;
	rte_data_t              found_q;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	logic [KEY_W-1:0] cell_key   [TABLE_ENTRIES+1];
	rte_data_t        cell_data  [TABLE_ENTRIES+1];
	logic             chain_hit  [TABLE_ENTRIES+1];
	rte_data_t        chain_found[TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] hit_vec;

	logic accept;
	logic any_hit;
	logic full;

	assign accept  = start && !busy;
	assign busy    = state_q != ST_IDLE;
	assign any_hit = chain_hit[TABLE_ENTRIES];
	assign full    = count_q == CNT_W'(TABLE_ENTRIES);

	// Query capture on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= rte_action_t'(action);
			key_q   <= dest_key[KEY_W-1:0];
			qdata_q <= '{hop: hop_key, cost: route_cost, stamp: route_stamp};
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				ctl.cmp_en = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				ctl.ins = (act_q == ACT_INSERT) && !any_hit && !full;
				ctl.upd = (act_q == ACT_UPDATE) && any_hit;
				ctl.rem = (act_q == ACT_REMOVE) && any_hit;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Entry count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_DONE;
			found_q  <= '0;
		end else begin
			done_q <= state_q == ST_EXEC;
			if (state_q == ST_EXEC) begin
				found_q <= '0;
				case (act_q)
					ACT_INSERT: begin
						if (any_hit) begin
							status_q <= STAT_DUP;
						end else if (full) begin
							status_q <= STAT_FULL;
						end else begin
							status_q <= STAT_DONE;
							count_q  <= count_q + 1'b1;
						end
					end
					ACT_REMOVE: begin
						status_q <= any_hit ? STAT_DONE : STAT_MISS;
						if (any_hit) begin
							count_q <= count_q - 1'b1;
						end
					end
					ACT_LOOKUP: begin
						status_q <= any_hit ? STAT_DONE : STAT_MISS;
						found_q  <= chain_found[TABLE_ENTRIES];
					end
					default: begin
						status_q <= any_hit ? STAT_DONE : STAT_MISS;
					end
				endcase
			end
		end
	end

	// Chain ends: nothing before the first cell, nothing past the last.
	assign chain_hit[0]              = 1'b0;
	assign chain_found[0]            = '0;
	assign cell_key[TABLE_ENTRIES]   = '0;
	assign cell_data[TABLE_ENTRIES]  = '0;

	// Row of entry cells.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		rte_cell #(
			.IDX   (i),
			.KEY_W (KEY_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.ctl       (ctl),
			.qkey      (key_q),
			.qdata     (qdata_q),
			.nxt_key   (cell_key[i+1]),
			.nxt_data  (cell_data[i+1]),
			.hit_in    (chain_hit[i]),
			.found_in  (chain_found[i]),
			.key_out   (cell_key[i]),
			.data_out  (cell_data[i]),
			.hit_out   (chain_hit[i+1]),
			.found_out (chain_found[i+1]),
			.hit_first (hit_vec[i])
		);
	end

	// Result ports.
	assign count_ext   = {{COUNT_W{1'b0}}, count_q};
	assign done        = done_q;
	assign status      = status_q;
	assign found_hop   = found_q.hop;
	assign found_cost  = found_q.cost;
	assign found_stamp = found_q.stamp;
	assign entry_count = count_ext[COUNT_W-1:0];

	// Keys are unique, so at most one cell can claim a match.
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> $onehot0(hit_vec))
		else $error("more than one cell matched the key");

	// The entry count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count exceeds table depth");

	// A refused insert leaves the table size alone.
	a_refuse_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == STAT_DUP || status_q == STAT_FULL) |-> $stable(count_q))
		else $error("refused insert changed the entry count");

	// Found fields are zero unless a lookup succeeded.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != STAT_DONE |-> found_q == '0)
		else $error("found fields set on a failed operation");

	// An accepted item reaches the execute state and then raises the registered done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 (state_q == ST_EXEC) ##1 done_q)
		else $error("result not produced on schedule");

endmodule

>>> sim/route_table_engine_top_tb.sv
// ----------------------------------------------------------------------------
// Route table engine testbench
// Drives insert, update, remove and lookup items through the start/busy
// handshake. A directed table covers the empty table, the extreme field
// values, duplicate and full refusals and removal from the middle and the
// top. A long random run follows, using a small key pool and fill and drain
// phases so that hits, misses, duplicates and a full table keep recurring.
// Each done strobe is checked field by field against a directed row's
// expected result or against a behavioral table kept in the testbench.
// ----------------------------------------------------------------------------
module route_table_engine_top_tb;
	import rte_pkg::*;

	localparam int RAND_ITEMS     = 1550;
	localparam int KEY_POOL       = 20;
	localparam int IDLE_PCT       = 13;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * RTE_ID_BYTES);

	// One result item as the block reports it.
	typedef struct packed {
		rte_status_t        status;
		logic [HOP_W-1:0]   hop;
		logic [COST_W-1:0]  cost;
		logic [STAMP_W-1:0] stamp;
		logic [COUNT_W-1:0] count;
	} route_result_t;

	// One row of the directed table. A row may repeat with the key stepping up.
	typedef struct packed {
		rte_action_t        act;
		logic [63:0]        key;
		logic [HOP_W-1:0]   hop;
		logic [COST_W-1:0]  cost;
		logic [STAMP_W-1:0] stamp;
		logic [4:0]         reps;
		bit                 typed;
		route_result_t      want;
	} dir_row_t;

	localparam route_result_t NO_RESULT = '0;
	localparam logic [63:0] ONES = {64{1'b1}};
	localparam logic [63:0] FILL_KEY = 64'h8000_0000_0000_0100;
	localparam logic [63:0] ODD_KEY  = 64'h5555_aaaa_5555_aaaa;
	localparam int DIR_ROWS = 21;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Empty table: every search misses.
		'{ACT_LOOKUP, 64'h0, 64'h0, 8'h00, 32'h0, 5'd1, 1'b1,
			'{STAT_MISS, 64'h0, 8'h00, 32'h0, 5'd0}},
		'{ACT_REMOVE, ONES, 64'h0, 8'h00, 32'h0, 5'd1, 1'b1,
			'{STAT_MISS, 64'h0, 8'h00, 32'h0, 5'd0}},
		'{ACT_UPDATE, 64'h5, ONES, 8'hff, 32'hffff_ffff, 5'd1, 1'b1,
			'{STAT_MISS, 64'h0, 8'h00, 32'h0, 5'd0}},
		// Extreme keys and payloads.
		'{ACT_INSERT, 64'h0, ONES, 8'hff, 32'hffff_ffff, 5'd1, 1'b1,
			'{STAT_DONE, 64'h0, 8'h00, 32'h0, 5'd1}},
		'{ACT_INSERT, 64'h0, 64'h1234, 8'h12, 32'h1234, 5'd1, 1'b1,
			'{STAT_DUP, 64'h0, 8'h00, 32'h0, 5'd1}},
		'{ACT_LOOKUP, 64'h0, 64'h0, 8'h00, 32'h0, 5'd1, 1'b1,
			'{STAT_DONE, ONES, 8'hff, 32'hffff_ffff, 5'd1}},
		'{ACT_INSERT, ONES, 64'h0, 8'h00, 32'h0, 5'd1, 1'b1,
			'{STAT_DONE, 64'h0, 8'h00, 32'h0, 5'd2}},
		'{ACT_LOOKUP, ONES, ONES, 8'hff, 32'hffff_ffff, 5'd1, 1'b1,
			'{STAT_DONE, 64'h0, 8'h00, 32'h0, 5'd2}},
		'{ACT_UPDATE, 64'h0, 64'h0123_4567_89ab_cdef, 8'h5a, 32'hdead_beef, 5'd1, 1'b0,
			NO_RESULT},
		'{ACT_LOOKUP, 64'h0, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		// Fill to capacity, then refuse; the duplicate check wins over full.
		'{ACT_INSERT, FILL_KEY, 64'hfedc_ba98_7654_3210, 8'ha5, 32'h0f0f_f0f0, 5'd14,
			1'b0, NO_RESULT},
		'{ACT_INSERT, ODD_KEY, ONES, 8'hff, 32'hffff_ffff, 5'd1, 1'b1,
			'{STAT_FULL, 64'h0, 8'h00, 32'h0, 5'd16}},
		'{ACT_INSERT, ONES, ONES, 8'hff, 32'hffff_ffff, 5'd1, 1'b1,
			'{STAT_DUP, 64'h0, 8'h00, 32'h0, 5'd16}},
		// Remove from the bottom, the top and the middle; later entries move down.
		'{ACT_REMOVE, 64'h0, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_LOOKUP, ONES, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_REMOVE, FILL_KEY + 64'd13, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_REMOVE, FILL_KEY + 64'd5, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_REMOVE, 64'h0, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_INSERT, ODD_KEY, 64'h0, 8'h01, 32'h1, 5'd1, 1'b0, NO_RESULT},
		'{ACT_LOOKUP, FILL_KEY + 64'd5, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT},
		'{ACT_LOOKUP, FILL_KEY + 64'd6, 64'h0, 8'h00, 32'h0, 5'd1, 1'b0, NO_RESULT}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	rte_action_t        action;
	logic [63:0]        dest_key;
	logic [HOP_W-1:0]   hop_key;
	logic [COST_W-1:0]  route_cost;
	logic [STAMP_W-1:0] route_stamp;
	logic               done;
	logic [1:0]         status;
	logic [HOP_W-1:0]   found_hop;
	logic [COST_W-1:0]  found_cost;
	logic [STAMP_W-1:0] found_stamp;
	logic [COUNT_W-1:0] entry_count;

	// Behavioral copy of the route table.
	logic [63:0]        tbl_key   [RTE_ENTRIES];
	logic [HOP_W-1:0]   tbl_hop   [RTE_ENTRIES];
	logic [COST_W-1:0]  tbl_cost  [RTE_ENTRIES];
	logic [STAMP_W-1:0] tbl_stamp [RTE_ENTRIES];
	int                 tbl_count;

	route_result_t pending_results [$];
	route_result_t mon_want;
	logic [63:0]   key_pool [KEY_POOL];

	int fail_count;
	int results_checked;
	int idle_pct;
	int stall_cycles;
	int action_tally [4];
	int status_tally [4];
	int peak_count;

	route_table_engine_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.dest_key    (dest_key),
		.hop_key     (hop_key),
		.route_cost  (route_cost),
		.route_stamp (route_stamp),
		.done        (done),
		.status      (status),
		.found_hop   (found_hop),
		.found_cost  (found_cost),
		.found_stamp (found_stamp),
		.entry_count (entry_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Apply one operation to the behavioral table and return its result.
	function automatic route_result_t apply_route_op(input rte_action_t act,
			input logic [63:0] key_in, input logic [HOP_W-1:0] hop,
			input logic [COST_W-1:0] cost, input logic [STAMP_W-1:0] stamp);
		route_result_t res;
		logic [63:0]   key;
		int            slot;
		key  = key_in & KEY_MASK;
		slot = RTE_ENTRIES;
		for (int i = tbl_count - 1; i >= 0; i--) begin
			if (tbl_key[i] == key)
				slot = i;
		end
		res        = '0;
		res.status = STAT_DONE;
		case (act)
			ACT_INSERT: begin
				if (slot < RTE_ENTRIES) begin
					res.status = STAT_DUP;
				end else if (tbl_count >= RTE_ENTRIES) begin
					res.status = STAT_FULL;
				end else begin
					tbl_key[tbl_count]   = key;
					tbl_hop[tbl_count]   = hop;
					tbl_cost[tbl_count]  = cost;
					tbl_stamp[tbl_count] = stamp;
					tbl_count++;
				end
			end
			ACT_UPDATE: begin
				if (slot < RTE_ENTRIES) begin
					tbl_hop[slot]   = hop;
					tbl_cost[slot]  = cost;
					tbl_stamp[slot] = stamp;
				end else begin
					res.status = STAT_MISS;
				end
			end
			ACT_REMOVE: begin
				if (slot < RTE_ENTRIES) begin
					// Close the gap so entries stay packed in insertion order.
					for (int j = slot; j + 1 < tbl_count; j++) begin
						tbl_key[j]   = tbl_key[j + 1];
						tbl_hop[j]   = tbl_hop[j + 1];
						tbl_cost[j]  = tbl_cost[j + 1];
						tbl_stamp[j] = tbl_stamp[j + 1];
					end
					tbl_count--;
					tbl_key[tbl_count]   = '0;
					tbl_hop[tbl_count]   = '0;
					tbl_cost[tbl_count]  = '0;
					tbl_stamp[tbl_count] = '0;
				end else begin
					res.status = STAT_MISS;
				end
			end
			default: begin
				if (slot < RTE_ENTRIES) begin
					res.hop   = tbl_hop[slot];
					res.cost  = tbl_cost[slot];
					res.stamp = tbl_stamp[slot];
				end else begin
					res.status = STAT_MISS;
				end
			end
		endcase
		res.count = COUNT_W'(tbl_count);
		return res;
	endfunction

	// Print one mismatch and count it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s of result %0d: got %h, expected %h",
			what, results_checked, got, want);
		fail_count++;
	endtask

	// Offer one item, wait until it is taken, and record what it should return.
	task automatic issue_op(input rte_action_t act, input logic [63:0] key,
			input logic [HOP_W-1:0] hop, input logic [COST_W-1:0] cost,
			input logic [STAMP_W-1:0] stamp, input bit typed,
			input route_result_t want);
		route_result_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start       <= 1'b1;
		action      <= act;
		dest_key    <= key;
		hop_key     <= hop;
		route_cost  <= cost;
		route_stamp <= stamp;
		do @(posedge clk); while (busy);
		predicted = apply_route_op(act, key, hop, cost, stamp);
		pending_results.push_back(typed ? want : predicted);
		action_tally[act]++;
		status_tally[predicted.status]++;
		if (tbl_count > peak_count)
			peak_count = tbl_count;
	endtask

	// Check every result strobe against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("result item arrived with nothing expected");
				fail_count++;
			end else begin
				mon_want = pending_results.pop_front();
				if (status !== mon_want.status)
					report_mismatch("status", 64'(status), 64'(mon_want.status));
				if (found_hop !== mon_want.hop)
					report_mismatch("found_hop", found_hop, mon_want.hop);
				if (found_cost !== mon_want.cost)
					report_mismatch("found_cost", 64'(found_cost), 64'(mon_want.cost));
				if (found_stamp !== mon_want.stamp)
					report_mismatch("found_stamp", 64'(found_stamp),
						64'(mon_want.stamp));
				if (entry_count !== mon_want.count)
					report_mismatch("entry_count", 64'(entry_count),
						64'(mon_want.count));
			end
			results_checked++;
		end
	end

	// End the run when neither side moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				pending_results.size());
			$display("FAIL route_table_engine_top");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random fill and drain phases.
	initial begin
		int          roll;
		bit          fill_phase;
		rte_action_t act;
		logic [63:0] key;
		fail_count      = 0;
		results_checked = 0;
		stall_cycles    = 0;
		peak_count      = 0;
		idle_pct        = IDLE_PCT;
		tbl_count       = 0;
		for (int i = 0; i < 4; i++) begin
			action_tally[i] = 0;
			status_tally[i] = 0;
		end
		for (int i = 0; i < RTE_ENTRIES; i++) begin
			tbl_key[i]   = '0;
			tbl_hop[i]   = '0;
			tbl_cost[i]  = '0;
			tbl_stamp[i] = '0;
		end
		arst_n      <= 1'b0;
		start       <= 1'b0;
		action      <= ACT_INSERT;
		dest_key    <= '0;
		hop_key     <= '0;
		route_cost  <= '0;
		route_stamp <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			for (int k = 0; k < dir_rows[r].reps; k++)
				issue_op(dir_rows[r].act, dir_rows[r].key + 64'(k), dir_rows[r].hop,
					dir_rows[r].cost, dir_rows[r].stamp, dir_rows[r].typed,
					dir_rows[r].want);
		end

		// A small pool keeps keys colliding, so hits and duplicates stay common.
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// A window with no sender gaps runs the block back to back.
			idle_pct   = (n >= 700 && n < 1000) ? 0 : IDLE_PCT;
			fill_phase = ((n / 100) % 2) == 0;
			roll       = $urandom_range(99);
			if (fill_phase)
				act = (roll < 50) ? ACT_INSERT : (roll < 62) ? ACT_UPDATE :
					(roll < 77) ? ACT_REMOVE : ACT_LOOKUP;
			else
				act = (roll < 15) ? ACT_INSERT : (roll < 30) ? ACT_UPDATE :
					(roll < 75) ? ACT_REMOVE : ACT_LOOKUP;
			if ($urandom_range(99) < 8)
				key = {$urandom, $urandom};
			else
				key = key_pool[$urandom_range(KEY_POOL - 1)];
			issue_op(act, key, {$urandom, $urandom}, COST_W'($urandom),
				$urandom, 1'b0, NO_RESULT);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts, %0d updates, %0d removes, %0d lookups; %0d results checked.",
			action_tally[ACT_INSERT], action_tally[ACT_UPDATE],
			action_tally[ACT_REMOVE], action_tally[ACT_LOOKUP], results_checked);
		$display("Outcomes: %0d done, %0d duplicate, %0d full, %0d not found; peak of %0d entries.",
			status_tally[STAT_DONE], status_tally[STAT_DUP], status_tally[STAT_FULL],
			status_tally[STAT_MISS], peak_count);
		if (fail_count == 0)
			$display("PASS route_table_engine_top");
		else
			$display("FAIL route_table_engine_top");
		$finish;
	end

endmodule
